[rtl/frcl_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and the quarter-wave cosine table generator for the fade/LFO block.
package frcl_pkg;

	// Divisor width (ramp length and period) and number of fraction bits of the phase.
	localparam int DIV_BITS      = 24;
	localparam int FRAC_BITS     = 16;
	localparam int LEVEL_BITS    = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam logic [16:0] ONE_Q16 = 17'd65536;

	// Configuration register indexes, in write-port order.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE,
		REG_START_LEVEL,
		REG_TARGET_LEVEL,
		REG_START_TIME,
		REG_RAMP_FRAMES,
		REG_PERIOD_LEN
	} cfg_reg_t;

	// Taylor coefficients of cos(pi/2 * u) in Q30, highest power first in Horner order.
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] COS_C1  = 64'd1324675879;
	localparam logic [63:0] COS_C2  = 64'd272375560;
	localparam logic [63:0] COS_C3  = 64'd22401992;
	localparam logic [63:0] COS_C4  = 64'd987048;
	localparam logic [63:0] COS_C5  = 64'd27060;

	// Ramp-side information that rides along the phase modulo pipeline.
	typedef struct packed {
		logic                neg;
		logic                done;
		logic [DIV_BITS-1:0] ramp_e;
	} ramp_side_t;

	// One quarter-wave table entry in Q16, evaluated at elaboration time only.
	function automatic logic [16:0] cos_entry(input int unsigned k, input int unsigned tb);
		logic [63:0] u;
		logic [63:0] w;
		logic [63:0] p;
		longint      c;
		u = 64'(k) << (30 - tb);
		w = (u * u) >> 30;
		p = COS_C5;
		p = COS_C4 - ((p * w) >> 30);
		p = COS_C3 - ((p * w) >> 30);
		p = COS_C2 - ((p * w) >> 30);
		p = COS_C1 - ((p * w) >> 30);
		c = longint'(Q30_ONE) - longint'((p * w) >> 30);
		c = (c + 64'sd8192) >>> 14;
		if (c < 0) begin
			c = 0;
		end
		if (c > 65536) begin
			c = 65536;
		end
		return 17'(c);
	endfunction

endpackage

[rtl/frcl_phase_mod.sv]
`timescale 1ns / 1ps
// Pipelined restoring remainder unit: one dividend bit per stage, elapsed time modulo the period.
module frcl_phase_mod #(
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [TIME_BITS-1:0]        mag,
	input  frcl_pkg::ramp_side_t        in_side,
	input  logic [frcl_pkg::DIV_BITS-1:0] den,
	output logic                        out_valid,
	output logic [frcl_pkg::DIV_BITS-1:0] rem,
	output frcl_pkg::ramp_side_t        out_side
);
	import frcl_pkg::*;

	logic                 v_s    [TIME_BITS];
	logic [DIV_BITS-1:0]  rem_s  [TIME_BITS];
	logic [TIME_BITS-1:0] mag_s  [TIME_BITS];
	ramp_side_t           side_s [TIME_BITS];

	for (genvar j = 0; j < TIME_BITS; j++) begin : g_stage
		logic                 pv;
		logic [DIV_BITS-1:0]  prem;
		logic [TIME_BITS-1:0] pmag;
		ramp_side_t           pside;
		logic [DIV_BITS+1:0]  trial;
		logic [DIV_BITS-1:0]  nrem;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = '0;
			assign pmag  = mag;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[j-1];
			assign prem  = rem_s[j-1];
			assign pmag  = mag_s[j-1];
			assign pside = side_s[j-1];
		end

		// Bring in the next dividend bit and subtract the divisor if it fits.
		assign trial = {1'b0, prem, pmag[TIME_BITS-1-j]} - {2'b00, den};
		assign nrem  = trial[DIV_BITS+1] ? {prem[DIV_BITS-2:0], pmag[TIME_BITS-1-j]}
		                                 : trial[DIV_BITS-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nrem;
				mag_s[j]  <= pmag;
				side_s[j] <= pside;
			end
		end
	end

	assign out_valid = v_s[TIME_BITS-1];
	assign rem       = rem_s[TIME_BITS-1];
	assign out_side  = side_s[TIME_BITS-1];

endmodule

[rtl/frcl_frac_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider that yields a 16-bit fractional quotient, one bit per stage.
module frcl_frac_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [frcl_pkg::DIV_BITS-1:0]  hi,
	input  logic [frcl_pkg::FRAC_BITS-1:0] lo,
	input  logic [frcl_pkg::DIV_BITS-1:0]  den,
	input  logic                           in_done,
	output logic                           out_valid,
	output logic [frcl_pkg::FRAC_BITS-1:0] quot,
	output logic [frcl_pkg::DIV_BITS-1:0]  rem,
	output logic                           out_done
);
	import frcl_pkg::*;

	logic                 v_s    [FRAC_BITS];
	logic [DIV_BITS-1:0]  rem_s  [FRAC_BITS];
	logic [FRAC_BITS-1:0] lo_s   [FRAC_BITS];
	logic [FRAC_BITS-1:0] q_s    [FRAC_BITS];
	logic                 done_s [FRAC_BITS];

	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_stage
		logic                 pv;
		logic [DIV_BITS-1:0]  prem;
		logic [FRAC_BITS-1:0] plo;
		logic [FRAC_BITS-1:0] pq;
		logic                 pdone;
		logic [DIV_BITS+1:0]  trial;
		logic [DIV_BITS-1:0]  nrem;

		if (j == 0) begin : g_first
			assign pv    = in_valid;
			assign prem  = hi;
			assign plo   = lo;
			assign pq    = '0;
			assign pdone = in_done;
		end else begin : g_next
			assign pv    = v_s[j-1];
			assign prem  = rem_s[j-1];
			assign plo   = lo_s[j-1];
			assign pq    = q_s[j-1];
			assign pdone = done_s[j-1];
		end

		// The partial remainder stays below the divisor, so one trial subtract per bit.
		assign trial = {1'b0, prem, plo[FRAC_BITS-1-j]} - {2'b00, den};
		assign nrem  = trial[DIV_BITS+1] ? {prem[DIV_BITS-2:0], plo[FRAC_BITS-1-j]}
		                                 : trial[DIV_BITS-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= nrem;
				lo_s[j]   <= plo;
				q_s[j]    <= {pq[FRAC_BITS-2:0], ~trial[DIV_BITS+1]};
				done_s[j] <= pdone;
			end
		end
	end

	assign out_valid = v_s[FRAC_BITS-1];
	assign quot      = q_s[FRAC_BITS-1];
	assign rem       = rem_s[FRAC_BITS-1];
	assign out_done  = done_s[FRAC_BITS-1];

endmodule

[rtl/frcl_cos_rom.sv]
`timescale 1ns / 1ps
// Quarter-wave cosine ROM with quadrant folding; gives the raised-cosine weight in Q16.
module frcl_cos_rom #(
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [frcl_pkg::FRAC_BITS-1:0] t16,
	output logic [16:0]                    s
);
	import frcl_pkg::*;

	localparam int N = 1 << COS_TABLE_BITS;
	localparam logic [COS_TABLE_BITS:0] N_VEC = (COS_TABLE_BITS + 1)'(N);

	logic [16:0]               rom_w [N+1];
	logic [COS_TABLE_BITS+1:0] idx;
	logic [1:0]                quad;
	logic [COS_TABLE_BITS-1:0] k;
	logic [COS_TABLE_BITS:0]   addr;
	logic [16:0]               c_s1;
	logic                      neg_s1;
	logic [17:0]               half;

	for (genvar g = 0; g <= N; g++) begin : g_rom
		localparam logic [16:0] ENTRY = cos_entry(g, COS_TABLE_BITS);
		assign rom_w[g] = ENTRY;
	end

	assign idx  = t16[FRAC_BITS-1 -: COS_TABLE_BITS+2];
	assign quad = idx[COS_TABLE_BITS+1 -: 2];
	assign k    = idx[COS_TABLE_BITS-1:0];
	// Odd quadrants read the table mirrored; the middle two quadrants are negative.
	assign addr = quad[0] ? (N_VEC - {1'b0, k}) : {1'b0, k};

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= rom_w[addr];
			neg_s1 <= quad[1] ^ quad[0];
		end
	end

	assign half = neg_s1 ? ({1'b0, ONE_Q16} + {1'b0, c_s1}) : ({1'b0, ONE_Q16} - {1'b0, c_s1});
	assign s    = half[17:1];

endmodule

[rtl/fade_ramp_and_cosine_lfo.sv]
`timescale 1ns / 1ps
// Top level of the fade ramp and raised-cosine LFO level generator.
// This block turns a frame time into a parameter level (volume, pan or speed) in signed Q4.12.
// In ramp mode the level runs in a straight line from start_level to target_level over
// ramp_frames frames after start_time and then holds at target_level with finished high; a zero
// ramp length finishes at once and times before the start give start_level. In oscillate mode
// the level swings between the two along a raised cosine whose period is set by the period
// register (zero acts as one), finished stays low, and times before the start wrap into the
// period. The block keeps no state from one word to the next, so it takes a new input word in
// every cycle while in_ready is high and gives one result word for each. Between accepting a
// word and giving its result, the word passes the front stage, loaded at the accepting edge,
// the pipelined remainder unit, which retires one time bit per stage, the numerator stage, a
// 16-stage fractional divider, a cosine table stage, a multiply stage and the output register.
// A two-word output buffer lets the pipeline keep accepting while a result waits; in_ready
// drops only once that buffer is full. Configuration registers may be written only while
// nothing is in flight.
module fade_ramp_and_cosine_lfo #(
	parameter int TIME_BITS      = 32,
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [frcl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [frcl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [TIME_BITS-1:0]                time_now,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [frcl_pkg::LEVEL_BITS-1:0] level,
	output logic                                finished
);
	import frcl_pkg::*;

	localparam int CMP_BITS = (TIME_BITS > DIV_BITS) ? TIME_BITS : DIV_BITS;

	// Configuration registers.
	logic                  mode_q;
	logic [LEVEL_BITS-1:0] start_level_q;
	logic [LEVEL_BITS-1:0] target_level_q;
	logic [TIME_BITS-1:0]  start_time_q;
	logic [DIV_BITS-1:0]   ramp_q;
	logic [DIV_BITS-1:0]   period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			start_level_q  <= '0;
			target_level_q <= '0;
			start_time_q   <= '0;
			ramp_q         <= '0;
			period_q       <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:          mode_q         <= cfg_data[0];
				REG_START_LEVEL:   start_level_q  <= cfg_data[LEVEL_BITS-1:0];
				REG_TARGET_LEVEL:  target_level_q <= cfg_data[LEVEL_BITS-1:0];
				REG_START_TIME:    start_time_q   <= TIME_BITS'(cfg_data);
				REG_RAMP_FRAMES:   ramp_q         <= cfg_data[DIV_BITS-1:0];
				REG_PERIOD_LEN:    period_q       <= cfg_data[DIV_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Values derived from configuration; the user keeps them fixed in flight, unenforced here.
	logic [DIV_BITS-1:0]          p_eff;
	logic [DIV_BITS-1:0]          frac_den;
	logic signed [LEVEL_BITS:0]   diff;
	logic [LEVEL_BITS:0]          diff_neg_v;
	logic [LEVEL_BITS-1:0]        diff_mag;

	assign p_eff      = (period_q == '0) ? DIV_BITS'(1) : period_q;
	assign frac_den   = mode_q ? p_eff : ramp_q;
	assign diff       = $signed({target_level_q[LEVEL_BITS-1], target_level_q})
	                  - $signed({start_level_q[LEVEL_BITS-1], start_level_q});
	assign diff_neg_v = -diff;
	assign diff_mag   = diff[LEVEL_BITS] ? diff_neg_v[LEVEL_BITS-1:0] : diff[LEVEL_BITS-1:0];

	// The whole pipeline moves together; it halts only when the output buffer is full.
	logic skid_full_q;
	logic en;

	assign en       = !skid_full_q;
	assign in_ready = en;

	// Front stage: elapsed time, its magnitude for the modulo unit and the ramp end test.
	logic [TIME_BITS:0]   fwd;
	logic [TIME_BITS-1:0] bwd;
	logic                 el_neg;
	logic [TIME_BITS-1:0] el_mag;
	logic                 past_end;
	logic                 ramp_done;
	ramp_side_t           side_in;

	assign fwd       = {1'b0, time_now} - {1'b0, start_time_q};
	assign bwd       = start_time_q - time_now;
	assign el_neg    = fwd[TIME_BITS];
	assign el_mag    = el_neg ? bwd : fwd[TIME_BITS-1:0];
	assign past_end  = !el_neg && (CMP_BITS'(el_mag) >= CMP_BITS'(ramp_q));
	assign ramp_done = !mode_q && ((ramp_q == '0) || past_end);

	always_comb begin
		side_in.neg    = el_neg;
		side_in.done   = ramp_done;
		side_in.ramp_e = (el_neg || ramp_done) ? '0 : DIV_BITS'(el_mag);
	end

	logic                 v_s1;
	logic [TIME_BITS-1:0] mag_s1;
	ramp_side_t           side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= el_mag;
			side_s1 <= side_in;
		end
	end

	// Elapsed magnitude modulo the period.
	logic                mod_v;
	logic [DIV_BITS-1:0] mod_rem;
	ramp_side_t          mod_side;

	frcl_phase_mod #(
		.TIME_BITS (TIME_BITS)
	) u_phase_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.mag       (mag_s1),
		.in_side   (side_s1),
		.den       (p_eff),
		.out_valid (mod_v),
		.rem       (mod_rem),
		.out_side  (mod_side)
	);

	// Numerator stage: floor-modulo fix-up for negative time, or the ramp product.
	logic [DIV_BITS-1:0]           phase_r;
	logic [DIV_BITS+FRAC_BITS-1:0] ramp_num;
	logic                          v_s2;
	logic [DIV_BITS-1:0]           hi_s2;
	logic [FRAC_BITS-1:0]          lo_s2;
	logic                          done_s2;

	assign phase_r  = (mod_side.neg && (mod_rem != '0)) ? (p_eff - mod_rem) : mod_rem;
	assign ramp_num = diff_mag * mod_side.ramp_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= mod_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hi_s2   <= mode_q ? phase_r : ramp_num[DIV_BITS+FRAC_BITS-1:FRAC_BITS];
			lo_s2   <= mode_q ? '0 : ramp_num[FRAC_BITS-1:0];
			done_s2 <= mod_side.done;
		end
	end

	// Fractional divide: phase in Q0.16 for the oscillator, ramp offset magnitude otherwise.
	logic                 fd_v;
	logic [FRAC_BITS-1:0] fd_q;
	logic [DIV_BITS-1:0]  fd_rem;
	logic                 fd_done;

	frcl_frac_div u_frac_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.hi        (hi_s2),
		.lo        (lo_s2),
		.den       (frac_den),
		.in_done   (done_s2),
		.out_valid (fd_v),
		.quot      (fd_q),
		.rem       (fd_rem),
		.out_done  (fd_done)
	);

	// Cosine table stage, with the ramp quotient carried alongside.
	logic [16:0]          cos_w;
	logic                 v_s3;
	logic [FRAC_BITS-1:0] q_s3;
	logic                 remnz_s3;
	logic                 done_s3;

	frcl_cos_rom #(
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_cos_rom (
		.clk (clk),
		.en  (en),
		.t16 (fd_q),
		.s   (cos_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= fd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3     <= fd_q;
			remnz_s3 <= (fd_rem != '0);
			done_s3  <= fd_done;
		end
	end

	// Multiply stage: raised-cosine product, or the floored signed ramp offset.
	logic [FRAC_BITS:0]           ramp_ceil;
	logic signed [FRAC_BITS+1:0]  ramp_pos;
	logic signed [FRAC_BITS+1:0]  ramp_off;
	logic signed [34:0]           osc_prod;
	logic                         v_s4;
	logic signed [FRAC_BITS+1:0]  delta_s4;
	logic                         done_s4;

	// A negative offset rounds toward minus infinity, so a nonzero remainder adds one.
	assign ramp_ceil = {1'b0, q_s3} + {{FRAC_BITS{1'b0}}, remnz_s3};
	assign ramp_pos  = $signed({1'b0, ramp_ceil});
	assign ramp_off  = diff[LEVEL_BITS] ? -ramp_pos : $signed({2'b00, q_s3});
	assign osc_prod  = diff * $signed({1'b0, cos_w});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s4 <= mode_q ? osc_prod[33:16] : ramp_off;
			done_s4  <= done_s3;
		end
	end

	// Final add; the level always lies between the two end levels, so it fits 16 bits.
	logic [FRAC_BITS+1:0]  level_sum;
	logic [LEVEL_BITS-1:0] level_next;
	logic                  push;
	logic                  pop;

	assign level_sum  = {{2{start_level_q[LEVEL_BITS-1]}}, start_level_q} + delta_s4;
	assign level_next = done_s4 ? target_level_q : level_sum[LEVEL_BITS-1:0];
	assign push       = en && v_s4;
	assign pop        = out_valid && out_ready;

	// Output register plus one skid word.
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic                  fin_q;
	logic [LEVEL_BITS-1:0] skid_level_q;
	logic                  skid_fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (pop) begin
				skid_full_q <= 1'b0;
			end
		end else if (push && out_valid_q && !pop) begin
			skid_full_q <= 1'b1;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (pop) begin
				level_q <= skid_level_q;
				fin_q   <= skid_fin_q;
			end
		end else if (push && out_valid_q && !pop) begin
			skid_level_q <= level_next;
			skid_fin_q   <= done_s4;
		end else if (push) begin
			level_q <= level_next;
			fin_q   <= done_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = $signed(level_q);
	assign finished  = fin_q;

endmodule
